// File: hdl/hse_pkg.sv
// shared types and constants for the heap sort engine
package hse_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    // input word: one value of the set
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_in_word;

    // output word: one value of the sorted run
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_word;

    // which entry wins a sift-down compare
    typedef enum logic [1:0] {
        PICK_NONE,
        PICK_LEFT,
        PICK_RIGHT
    } t_pick;

endpackage

// File: hdl/hse_mem.sv
// value store: one write port, two registered read ports
module hse_mem #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [hse_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                    i_raddr_a,
    input  logic [AW-1:0]                    i_raddr_b,
    output logic signed [hse_pkg::DATA_W-1:0] o_rdata_a,
    output logic signed [hse_pkg::DATA_W-1:0] o_rdata_b
);
    import hse_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/hse_cmp.sv
// shared compare unit: picks the largest of a node value and its children
module hse_cmp (
    input  logic signed [hse_pkg::DATA_W-1:0] i_cur,
    input  logic signed [hse_pkg::DATA_W-1:0] i_left,
    input  logic signed [hse_pkg::DATA_W-1:0] i_right,
    input  logic                              i_left_ok,
    input  logic                              i_right_ok,
    output hse_pkg::t_pick                    o_pick,
    output logic signed [hse_pkg::DATA_W-1:0] o_win
);
    import hse_pkg::*;

    logic signed [DATA_W-1:0] top_val;
    t_pick                    pick;

    // left child first, then right child against the running winner
    always_comb begin
        top_val = i_cur;
        pick    = PICK_NONE;
        if (i_left_ok && (i_left > top_val)) begin
            top_val = i_left;
            pick    = PICK_LEFT;
        end
        if (i_right_ok && (i_right > top_val)) begin
            top_val = i_right;
            pick    = PICK_RIGHT;
        end
    end

    assign o_pick = pick;
    assign o_win  = top_val;

endmodule

// File: hdl/heap_sort_engine.sv
// heap sort engine top level: load, heap sort sequencer and output register
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one signed value per
// word; a word with is_last set closes the set and starts the sort. Words that
// arrive with the store full (DEPTH entries) are dropped, and every word of that
// run then carries overflow. Output channel (o_out_valid / i_out_ready /
// o_out_word) delivers the set in ascending order, last_out on the greatest.
// While loading, the input stays ready. The sort runs on one compare unit and
// one two-read, one-write store: each level a value moves down is a child read,
// then a compare and write back, and every sift adds three steps (node or root
// and end read, node take or root swap, final placement). Emission reads each
// result from the store, then hands it to the output register when that is
// free; a stalled receiver holds the output register and the sequencer waits.
// The input is not ready from the last word of a set until the final result is
// placed in the output register. Synchronous reset clears the count, the
// overflow flag, the sequencer and the output valid; the store is not cleared,
// only entries written in the current set are read.
module heap_sort_engine #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hse_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hse_pkg::t_out_word o_out_word
);
    import hse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BREAD,
        ST_GRAB,
        ST_FETCH,
        ST_CMP,
        ST_XREAD,
        ST_XSWAP,
        ST_EREAD,
        ST_EOUT
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_drop, n_drop;
    logic [CW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_len, n_len;
    logic [AW-1:0]        r_node, n_node;
    logic [AW-1:0]        r_e, n_e;
    logic                 r_build, n_build;
    logic signed [DATA_W-1:0] r_cur, n_cur;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word, n_out_word;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic signed [DATA_W-1:0] rdata_a, rdata_b;

    logic [LW-1:0]        lc, rc;
    logic                 lc_ok, rc_ok;
    t_pick                pick;
    logic signed [DATA_W-1:0] win;
    logic [CW-1:0]        k_dec;
    logic [CW-1:0]        count_inc;
    logic                 room;
    logic                 out_free;

    // child indexes of the current node
    assign lc    = {1'b0, r_node, 1'b1};
    assign rc    = lc + LW'(1);
    assign lc_ok = lc < LW'(r_len);
    assign rc_ok = rc < LW'(r_len);

    assign k_dec     = r_k - CW'(1);
    assign count_inc = r_count + CW'(1);
    assign room      = r_count < CW'(DEPTH);
    assign out_free  = !r_out_valid || i_out_ready;

    hse_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    hse_cmp u_cmp (
        .i_cur      (r_cur),
        .i_left     (rdata_a),
        .i_right    (rdata_b),
        .i_left_ok  (lc_ok),
        .i_right_ok (rc_ok),
        .o_pick     (pick),
        .o_win      (win)
    );

    // store read addresses per state
    always_comb begin
        raddr_a = lc[AW-1:0];
        raddr_b = rc[AW-1:0];
        unique case (r_state)
            ST_BREAD: begin
                raddr_a = r_node;
            end
            ST_XREAD: begin
                raddr_a = '0;
                raddr_b = k_dec[AW-1:0];
            end
            ST_EREAD, ST_EOUT: begin
                raddr_a = r_e;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state and store write
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_k         = r_k;
        n_len       = r_len;
        n_node      = r_node;
        n_e         = r_e;
        n_build     = r_build;
        n_cur       = r_cur;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = win;

        unique case (r_state)
            // collect words until one marked last
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (room) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = i_in_word.value;
                        n_count   = count_inc;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_word.is_last) begin
                        n_k     = n_count >> 1;
                        n_len   = n_count;
                        n_build = 1'b1;
                        n_e     = '0;
                        if ((n_count >> 1) != '0) begin
                            n_node  = AW'((n_count >> 1) - CW'(1));
                            n_state = ST_BREAD;
                        end else begin
                            n_state = ST_EREAD;
                        end
                    end
                end
            end
            // heap build: read the node to sift
            ST_BREAD: begin
                n_state = ST_GRAB;
            end
            // take the node value, children reads in flight
            ST_GRAB: begin
                n_cur   = rdata_a;
                n_state = ST_CMP;
            end
            ST_FETCH: begin
                n_state = ST_CMP;
            end
            // one sift-down level: move the larger child up or place the value
            ST_CMP: begin
                mem_we = 1'b1;
                if (pick != PICK_NONE) begin
                    n_node  = (pick == PICK_LEFT) ? lc[AW-1:0] : rc[AW-1:0];
                    n_state = ST_FETCH;
                end else if (r_build) begin
                    if (k_dec != '0) begin
                        n_k     = k_dec;
                        n_node  = AW'(k_dec - CW'(1));
                        n_state = ST_BREAD;
                    end else if (r_count > CW'(1)) begin
                        n_build = 1'b0;
                        n_k     = r_count;
                        n_node  = '0;
                        n_state = ST_XREAD;
                    end else begin
                        n_e     = '0;
                        n_state = ST_EREAD;
                    end
                end else begin
                    if (k_dec > CW'(1)) begin
                        n_k     = k_dec;
                        n_node  = '0;
                        n_state = ST_XREAD;
                    end else begin
                        n_e     = '0;
                        n_state = ST_EREAD;
                    end
                end
            end
            // extraction: read root and heap end
            ST_XREAD: begin
                n_len   = k_dec;
                n_state = ST_XSWAP;
            end
            // root goes to the end, old end value sifts from the root
            ST_XSWAP: begin
                mem_we    = 1'b1;
                mem_waddr = k_dec[AW-1:0];
                mem_wdata = rdata_a;
                n_cur     = rdata_b;
                n_state   = ST_CMP;
            end
            ST_EREAD: begin
                n_state = ST_EOUT;
            end
            // hand one sorted word to the output register
            ST_EOUT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_word.sorted_value = rdata_a;
                    n_out_word.last_out     = (CW'(r_e) + CW'(1)) == r_count;
                    n_out_word.overflow     = r_drop;
                    if ((CW'(r_e) + CW'(1)) == r_count) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_e     = r_e + AW'(1);
                        n_state = ST_EREAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_len      <= n_len;
        r_node     <= n_node;
        r_e        <= n_e;
        r_build    <= n_build;
        r_cur      <= n_cur;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: sim/heap_sort_engine_tb.sv
// testbench for the heap sort engine: sets of signed words checked against an in-bench sorter
module heap_sort_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hse_pkg::*;

    localparam int          STORE_DEPTH = DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          TAIL_CYCLES = 64;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_word   in_word   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;

    // idle rates in percent for each side
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 58;

    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;

    // shadow of the block: loaded set, count and drop flag
    logic signed [DATA_W-1:0] set_mem [STORE_DEPTH];
    int unsigned              set_cnt     = 0;
    bit                       set_dropped = 1'b0;

    // sorted words still owed by the block, oldest first
    t_out_word sorted_q [$];

    heap_sort_engine #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[heap_sort_engine] ERROR");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // load one accepted word; on the closing word sort the set and queue the run
    task automatic load_and_sort(input t_in_word w);
        logic signed [DATA_W-1:0] run [STORE_DEPTH];
        logic signed [DATA_W-1:0] key;
        t_out_word                ow;
        int                       j;
        if (set_cnt < STORE_DEPTH) begin
            set_mem[set_cnt] = w.value;
            set_cnt++;
        end else begin
            set_dropped = 1'b1;
        end
        if (w.is_last) begin
            // insertion sort, ascending signed
            for (int i = 0; i < set_cnt; i++) begin
                key = set_mem[i];
                j = i - 1;
                while (j >= 0 && run[j] > key) begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = key;
            end
            for (int i = 0; i < set_cnt; i++) begin
                ow.sorted_value = run[i];
                ow.last_out     = (i == set_cnt - 1);
                ow.overflow     = set_dropped;
                sorted_q.push_back(ow);
            end
            set_cnt     = 0;
            set_dropped = 1'b0;
        end
    endtask

    // output checker
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n && out_valid && out_ready) begin
            if (sorted_q.size() == 0) begin
                $error("unexpected word: sorted_value %0d", $signed(out_word.sorted_value));
                err_cnt++;
            end else begin
                exp_w = sorted_q.pop_front();
                if (out_word.sorted_value !== exp_w.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           $signed(exp_w.sorted_value), $signed(out_word.sorted_value));
                    err_cnt++;
                end
                if (out_word.last_out !== exp_w.last_out) begin
                    $error("last_out: expected %0b, got %0b", exp_w.last_out, out_word.last_out);
                    err_cnt++;
                end
                if (out_word.overflow !== exp_w.overflow) begin
                    $error("overflow: expected %0b, got %0b", exp_w.overflow, out_word.overflow);
                    err_cnt++;
                end
            end
        end
    end

    // send one word, called and returning at a falling edge
    task automatic send_word(input logic [DATA_W-1:0] v, input bit last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid        <= 1'b1;
        in_word.value   <= v;
        in_word.is_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        load_and_sort(in_word);
        @(negedge clk);
    endtask

    task automatic send_set(input logic [DATA_W-1:0] vals [$]);
        foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
    endtask

    // hold the input off until the block has delivered every owed word
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // mostly full-range values, some in a narrow band for repeats, some extremes
    function automatic logic [DATA_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom;
        if (r < 9) return $urandom_range(0, 15) - 32'd8;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_random_set(input int unsigned len);
        logic [DATA_W-1:0] vals [$];
        for (int i = 0; i < len; i++) vals.push_back(rand_value());
        send_set(vals);
    endtask

    // field extremes and alternating bit patterns in one set
    task automatic test_extremes();
        send_set('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001,
                   32'h7FFF_FFFE});
    endtask

    // one-word set and a two-word set in falling order
    task automatic test_short_sets();
        send_set('{32'hFFFF_FFFB});
        send_set('{32'd100, 32'hFFFF_FF9C});
    endtask

    // repeated values, including a set of all-equal words
    task automatic test_equal_values();
        send_set('{32'd3, 32'd3, 32'hFFFF_FFFD, 32'd3, 32'hFFFF_FFFD, 32'd3});
        send_set('{32'd7, 32'd7, 32'd7, 32'd7});
    endtask

    // store filled to the last entry, then the closing word is dropped
    task automatic test_store_full();
        send_random_set(STORE_DEPTH + 1);
    endtask

    // random sets, mostly small, now and then a mid-size one
    task automatic test_random_sets(input int unsigned s_pct, input int unsigned r_pct,
                                    input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 19);
            if (r < 4) len = $urandom_range(9, 16);
            else       len = $urandom_range(1, 8);
            send_random_set(len);
            sent += len;
        end
        drain_results();
    endtask

    // test sequence
    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_short_sets();
        test_equal_values();
        drain_results();
        test_store_full();
        drain_results();

        test_random_sets(31, 58, 4);
        test_random_sets(58, 31, 4);
        test_random_sets(0, 0, 4);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_cnt == 0 && sorted_q.size() == 0) begin
            $display("[heap_sort_engine] OK");
        end else begin
            $display("[heap_sort_engine] ERROR");
        end
        $finish;
    end

endmodule
